// ----- hw/rtl/bbe_pkg.sv -----
// ============================================================================
// bbe_pkg
// Shared types and codes for the MSB-first bitstream bit extractor.
// ============================================================================
package bbe_pkg;

    // Operation codes
    localparam logic [2:0] OP_PUSH = 3'd0;
    localparam logic [2:0] OP_READ = 3'd1;
    localparam logic [2:0] OP_PEEK = 3'd2;
    localparam logic [2:0] OP_SKIP = 3'd3;
    localparam logic [2:0] OP_BYTE = 3'd4;

    // Status codes
    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_SHORT = 2'd1;
    localparam logic [1:0] ST_FULL  = 2'd2;
    localparam logic [1:0] ST_BAD   = 2'd3;

    localparam int POS_W   = 48;
    localparam int VALUE_W = 64;

    // Request word, last field in the lowest bits
    typedef struct packed {
        logic [6:0] nbits;
        logic [7:0] byte_in;
        logic [2:0] op;
    } t_req;

    // Response word, last field in the lowest bits
    typedef struct packed {
        logic [POS_W-1:0]   bit_position;
        logic [1:0]         status;
        logic [VALUE_W-1:0] value;
    } t_rsp;

endpackage

// ----- hw/rtl/bbe_pipe_reg.sv -----
// ============================================================================
// bbe_pipe_reg
// One-entry valid/ready register stage; takes a new word whenever it is
// empty or its content leaves in the same cycle.
// ============================================================================
module bbe_pipe_reg #(
    parameter int DATA_W = 8
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    output logic              o_ready,
    input  logic [DATA_W-1:0] i_data,
    output logic              o_valid,
    input  logic              i_ready,
    output logic [DATA_W-1:0] o_data
);

    logic              r_valid;
    logic [DATA_W-1:0] r_data;

    assign o_ready = !r_valid || i_ready;
    assign o_valid = r_valid;
    assign o_data  = r_data;

    // Occupancy flag
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    // Payload, no reset needed
    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_data <= i_data;
        end
    end

endmodule

// ----- hw/rtl/bbe_exec.sv -----
// ============================================================================
// bbe_exec
// Window store, read pointer and position counter, with the combinational
// barrel extraction and state update for one request.
// ============================================================================
module bbe_exec
    import bbe_pkg::*;
#(
    parameter int WINDOW_BYTES  = 16,
    parameter int MAX_READ_BITS = 64
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_fire,
    input  t_req i_req,
    output t_rsp o_rsp
);

    localparam int WIN_W = WINDOW_BYTES * 8;
    localparam int BUF_W = $clog2(WINDOW_BYTES + 1);
    localparam int IDX_W = $clog2(WINDOW_BYTES);
    localparam int AV_W  = BUF_W + 3;
    localparam int TOT_W = $clog2(7 + MAX_READ_BITS + 1);
    localparam int DROP_W = TOT_W - 3;

    logic [7:0]       r_win [WINDOW_BYTES];
    logic [2:0]       r_rbi;
    logic [BUF_W-1:0] r_buf;
    logic [POS_W-1:0] r_pos;

    logic [2:0]         n_rbi;
    logic [BUF_W-1:0]   n_buf;
    logic [POS_W-1:0]   n_pos;

    logic [WIN_W-1:0]         win_flat;
    logic [WIN_W-1:0]         win_at_rbi;
    logic [WIN_W-1:0]         win_shift;
    logic [MAX_READ_BITS-1:0] top_bits;
    logic [MAX_READ_BITS-1:0] ext_bits;
    logic [6:0]               rsh;
    logic [AV_W-1:0]          avail;
    logic                     bad_len;
    logic                     short_bits;
    logic [6:0]               cnt;
    logic [TOT_W-1:0]         total;
    logic [DROP_W-1:0]        drop;
    logic                     do_push;
    logic                     do_adv;
    logic [VALUE_W-1:0]       value;
    logic [1:0]               status;

    // Window as one MSB-first vector, entry 0 on top
    always_comb begin
        for (int i = 0; i < WINDOW_BYTES; i++) begin
            win_flat[WIN_W-1-8*i -: 8] = r_win[i];
        end
    end

    // Barrel extraction: align to the read pointer, keep nbits right-aligned
    assign win_at_rbi = win_flat << r_rbi;
    assign top_bits   = win_at_rbi[WIN_W-1 -: MAX_READ_BITS];
    assign rsh        = 7'(MAX_READ_BITS) - i_req.nbits;
    assign ext_bits   = top_bits >> rsh;

    assign avail      = {r_buf, 3'b000} - AV_W'(r_rbi);
    assign bad_len    = (i_req.nbits == 7'd0) || (i_req.nbits > 7'(MAX_READ_BITS));
    assign short_bits = AV_W'(i_req.nbits) > avail;

    // Request decode
    always_comb begin
        value   = '0;
        status  = ST_OK;
        do_push = 1'b0;
        do_adv  = 1'b0;
        cnt     = i_req.nbits;
        unique case (i_req.op) inside
            OP_PUSH: begin
                if (r_buf >= BUF_W'(WINDOW_BYTES)) begin
                    status = ST_FULL;
                end else begin
                    do_push = 1'b1;
                end
            end
            OP_READ, OP_PEEK, OP_SKIP: begin
                if (bad_len) begin
                    status = ST_BAD;
                end else if (short_bits) begin
                    status = ST_SHORT;
                end else begin
                    if (i_req.op != OP_SKIP) begin
                        value = VALUE_W'(ext_bits);
                    end
                    do_adv = (i_req.op != OP_PEEK);
                end
            end
            OP_BYTE: begin
                cnt = 7'd8;
                if (r_rbi != 3'd0) begin
                    status = ST_BAD;
                end else if (r_buf == '0) begin
                    status = ST_SHORT;
                end else begin
                    value  = VALUE_W'(r_win[0]);
                    do_adv = 1'b1;
                end
            end
            default: begin
                status = ST_BAD;
            end
        endcase
    end

    // Advance: whole consumed bytes leave the window
    assign total     = TOT_W'(r_rbi) + TOT_W'(cnt);
    assign drop      = total[TOT_W-1:3];
    assign win_shift = win_flat << {drop, 3'b000};

    always_comb begin
        n_rbi = r_rbi;
        n_buf = r_buf;
        n_pos = r_pos;
        if (do_push) begin
            n_buf = r_buf + BUF_W'(1);
        end else if (do_adv) begin
            n_rbi = total[2:0];
            n_buf = r_buf - BUF_W'(drop);
            n_pos = r_pos + POS_W'(cnt);
        end
    end

    assign o_rsp.value        = value;
    assign o_rsp.status       = status;
    assign o_rsp.bit_position = n_pos;

    // Control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rbi <= 3'd0;
            r_buf <= '0;
            r_pos <= '0;
        end else if (i_fire) begin
            r_rbi <= n_rbi;
            r_buf <= n_buf;
            r_pos <= n_pos;
        end
    end

    // Window entries, undefined until written
    always_ff @(posedge i_clk) begin
        for (int i = 0; i < WINDOW_BYTES; i++) begin
            if (i_fire && do_push && (r_buf[IDX_W-1:0] == IDX_W'(i))) begin
                r_win[i] <= i_req.byte_in;
            end else if (i_fire && do_adv) begin
                r_win[i] <= win_shift[WIN_W-1-8*i -: 8];
            end
        end
    end

endmodule

// ----- hw/rtl/bitstream_bit_extractor_core.sv -----
// ============================================================================
// bitstream_bit_extractor_core
// MSB-first bitstream reader with byte push, read, peek, skip and
// aligned byte requests.
// ============================================================================
// Usage:
//   Slave channel (i_s_*): one request word per handshake: op, byte_in, nbits.
//   Master channel (o_m_*): exactly one response word per request, in order:
//   value, status, bit_position.
//   Pushes fill a window of WINDOW_BYTES bytes; reads take 1..MAX_READ_BITS
//   bits MSB first from it. A failing request leaves all state unchanged.
//   From request handshake to response valid the path is one input
//   register, then the barrel extractor and state update feeding the
//   response register. Throughput is one word per cycle while the
//   receiver keeps up.
//   Reset (synchronous, active low) empties the window, clears the read
//   pointer and the bit position, and drops any words in flight.
//   When the receiver stalls, the response register holds; one more request
//   is taken into the input register, after which o_s_tready drops until
//   the response leaves.
// ============================================================================
module bitstream_bit_extractor_core
    import bbe_pkg::*;
#(
    parameter int WINDOW_BYTES  = 16,
    parameter int MAX_READ_BITS = 64
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_s_tvalid,
    output logic         o_s_tready,
    input  logic [23:0]  i_s_tdata,   // op[2:0], byte_in[10:3], nbits[17:11]
    output logic         o_m_tvalid,
    input  logic         i_m_tready,
    output logic [119:0] o_m_tdata    // value[63:0], status[65:64], bit_position[113:66]
);

    localparam int REQ_W = $bits(t_req);
    localparam int RSP_W = $bits(t_rsp);

    logic       req_valid;
    logic       rsp_ready;
    logic       fire;
    t_req       req;
    t_rsp       rsp;
    t_rsp       rsp_q;

    // Request register
    bbe_pipe_reg #(
        .DATA_W (REQ_W)
    ) u_in_reg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_s_tvalid),
        .o_ready (o_s_tready),
        .i_data  (i_s_tdata[REQ_W-1:0]),
        .o_valid (req_valid),
        .i_ready (rsp_ready),
        .o_data  (req)
    );

    assign fire = req_valid && rsp_ready;

    // Window and extraction
    bbe_exec #(
        .WINDOW_BYTES  (WINDOW_BYTES),
        .MAX_READ_BITS (MAX_READ_BITS)
    ) u_exec (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_fire  (fire),
        .i_req   (req),
        .o_rsp   (rsp)
    );

    // Response register
    bbe_pipe_reg #(
        .DATA_W (RSP_W)
    ) u_out_reg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (req_valid),
        .o_ready (rsp_ready),
        .i_data  (rsp),
        .o_valid (o_m_tvalid),
        .i_ready (i_m_tready),
        .o_data  (rsp_q)
    );

    assign o_m_tdata = {(120 - RSP_W)'(0), rsp_q};

endmodule

// ----- hw/rtl/bbe_checker.sv -----
// ============================================================================
// bbe_checker
// Port-level checks for the bitstream bit extractor, bound to the top level.
// ============================================================================
module bbe_checker
    import bbe_pkg::*;
(
    input logic         i_clk,
    input logic         i_rst_n,
    input logic         i_s_tvalid,
    input logic         o_s_tready,
    input logic [23:0]  i_s_tdata,
    input logic         o_m_tvalid,
    input logic         i_m_tready,
    input logic [119:0] o_m_tdata
);

    // Reset empties the response register
    a_rst_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_m_tvalid)
        else $error("response valid after reset");

    // Stalled response word holds
    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && !i_m_tready |=> o_m_tvalid && $stable(o_m_tdata))
        else $error("stalled response changed");

    // Input only backs up when a response is waiting
    a_ready_low: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_s_tready |-> o_m_tvalid && !i_m_tready)
        else $error("input stalled without output backpressure");

    // Failed requests return a zero value
    a_fail_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && (o_m_tdata[65:64] != ST_OK) |-> o_m_tdata[63:0] == 64'd0)
        else $error("nonzero value on failed request");

endmodule

bind bitstream_bit_extractor_core bbe_checker u_bbe_checker (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .i_s_tvalid (i_s_tvalid),
    .o_s_tready (o_s_tready),
    .i_s_tdata  (i_s_tdata),
    .o_m_tvalid (o_m_tvalid),
    .i_m_tready (i_m_tready),
    .o_m_tdata  (o_m_tdata)
);

// ----- sim/bitstream_bit_extractor_core_tb.sv -----
// ============================================================================
// bitstream_bit_extractor_core_tb
// Drives request words (push, read, peek, skip, aligned byte) into the
// extractor. A bit-level window model predicts every response word, and each
// response is checked field by field in order. A short directed sequence comes
// first, then random traffic that is mostly well formed. Both channels idle at
// random, and the receiver holds off once long enough to back up the core.
// ============================================================================
`timescale 1ns / 100ps

module bitstream_bit_extractor_core_tb
    import bbe_pkg::*;
();

    localparam int CLK_PERIOD   = 8;
    localparam int WIN_BYTES    = 16;
    localparam int WIN_W        = WIN_BYTES * 8;
    localparam int MAX_BITS     = 64;
    localparam int RAND_ITEMS   = 1150;
    localparam int STALL_LIMIT  = 2000;
    localparam int DRAIN_CYCLES = 8;
    localparam int IDLE_PCT     = 34;
    localparam int HOLD_AT      = 800;
    localparam int HOLD_CYCLES  = 90;
    localparam int PRINT_CAP    = 50;

    // Opcode beyond the defined range, used to hit the unknown-op path
    localparam logic [2:0] OP_UNDEF_TOP = 3'd7;

    // Test pattern loaded by the directed fill, first byte in the top bits
    localparam logic [WIN_W-1:0] FILL_PATTERN = 128'hFF00_A55A_8001_7FFE_C33C_1234_5678_9ABC;

    // Window state of the bit reader, entry 0 in the top byte
    typedef struct packed {
        logic [WIN_W-1:0] win;
        logic [2:0]       bidx;
        logic [4:0]       nbuf;
        logic [POS_W-1:0] pos;
    } t_bitreader;

    logic         i_clk      = 1'b0;
    logic         i_rst_n    = 1'b0;
    logic         i_s_tvalid = 1'b0;
    logic         o_s_tready;
    logic [23:0]  i_s_tdata  = '0;  // op[2:0], byte_in[10:3], nbits[17:11]
    logic         o_m_tvalid;
    logic         i_m_tready = 1'b0;
    logic [119:0] o_m_tdata;        // value[63:0], status[65:64], bit_position[113:66]

    t_req       request_words[$];
    t_rsp       expected_words[$];
    t_bitreader gen_state   = '0;
    t_bitreader check_state = '0;

    logic s_took      = 1'b0;
    int   sent_cnt    = 0;
    int   rsp_cnt     = 0;
    int   err_cnt     = 0;
    int   hold_left   = 0;
    logic hold_done   = 1'b0;
    int   idle_cycles = 0;
    int   op_seen[8];
    int   status_seen[4];

    bitstream_bit_extractor_core dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata)
    );

    always #(CLK_PERIOD / 2) i_clk = ~i_clk;

    // Bit reader: applies one request word to a window state, returns the reply
    task automatic predict_bitreader(inout t_bitreader st, input t_req rq, output t_rsp rs);
        logic [WIN_W-1:0] aligned;
        int avail;
        int adv;
        int total;
        int nb;
        rs        = '0;
        rs.status = ST_OK;
        nb        = int'(st.nbuf);
        avail     = nb * 8 - int'(st.bidx);
        adv       = 0;
        case (rq.op) inside
            OP_PUSH: begin
                if (nb >= WIN_BYTES) begin
                    rs.status = ST_FULL;
                end else begin
                    st.win  = st.win | ({rq.byte_in, {(WIN_W-8){1'b0}}} >> (8 * nb));
                    st.nbuf = st.nbuf + 1'b1;
                end
            end
            OP_READ, OP_PEEK, OP_SKIP: begin
                if (rq.nbits == 0 || rq.nbits > MAX_BITS) begin
                    rs.status = ST_BAD;
                end else if (int'(rq.nbits) > avail) begin
                    rs.status = ST_SHORT;
                end else begin
                    if (rq.op != OP_SKIP) begin
                        aligned  = st.win << st.bidx;
                        rs.value = aligned[WIN_W-1 -: VALUE_W] >> (VALUE_W - int'(rq.nbits));
                    end
                    if (rq.op != OP_PEEK)
                        adv = int'(rq.nbits);
                end
            end
            OP_BYTE: begin
                if (st.bidx != 0) begin
                    rs.status = ST_BAD;
                end else if (nb < 1) begin
                    rs.status = ST_SHORT;
                end else begin
                    rs.value = VALUE_W'(st.win[WIN_W-1 -: 8]);
                    adv      = 8;
                end
            end
            default: rs.status = ST_BAD;
        endcase
        // consume bits, dropping fully used bytes from the front
        if (adv != 0) begin
            total   = int'(st.bidx) + adv;
            st.win  = st.win << (8 * (total / 8));
            st.nbuf = st.nbuf - 5'(total / 8);
            st.bidx = 3'(total % 8);
            st.pos  = st.pos + POS_W'(adv);
        end
        rs.bit_position = st.pos;
    endtask

    // Queue a request word and track the window so random traffic stays mostly legal
    task automatic add_request(input logic [2:0] op, input logic [7:0] b, input logic [6:0] n);
        t_req r;
        t_rsp unused;
        r.op      = op;
        r.byte_in = b;
        r.nbits   = n;
        predict_bitreader(gen_state, r, unused);
        request_words.push_back(r);
    endtask

    task automatic report_mismatch(input string what, input logic [63:0] got,
                                   input logic [63:0] want);
        if (err_cnt < PRINT_CAP)
            $display("MISMATCH reply %0d %s: got %h want %h", rsp_cnt, what, got, want);
        err_cnt++;
    endtask

    // Sender: offers queued words at the falling edge, random gaps
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            i_s_tvalid <= 1'b0;
        end else if (!i_s_tvalid || s_took) begin
            if (request_words.size() > 0 &&
                ((sent_cnt >= 450 && sent_cnt < 650) || $urandom_range(99) >= IDLE_PCT)) begin
                i_s_tdata  <= {6'b0, request_words.pop_front()};
                i_s_tvalid <= 1'b1;
                sent_cnt   <= sent_cnt + 1;
            end else begin
                i_s_tvalid <= 1'b0;
            end
        end
    end

    // Receiver: random ready, one long hold-off, one stretch always ready
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            i_m_tready <= 1'b0;
        end else if (hold_left > 0) begin
            i_m_tready <= 1'b0;
            hold_left  <= hold_left - 1;
        end else if (rsp_cnt >= HOLD_AT && !hold_done) begin
            i_m_tready <= 1'b0;
            hold_left  <= HOLD_CYCLES;
            hold_done  <= 1'b1;
        end else if (rsp_cnt >= 450 && rsp_cnt < 650) begin
            i_m_tready <= 1'b1;
        end else begin
            i_m_tready <= ($urandom_range(99) >= IDLE_PCT);
        end
    end

    // Monitor: predicts on accepted requests, checks accepted responses
    always @(posedge i_clk) begin : monitor
        t_req rq;
        t_rsp got;
        t_rsp want;
        if (!i_rst_n) begin
            s_took <= 1'b0;
        end else begin
            s_took <= i_s_tvalid && o_s_tready;
            if (o_m_tvalid && i_m_tready) begin
                got = o_m_tdata[$bits(t_rsp)-1:0];
                if (expected_words.size() == 0) begin
                    report_mismatch("unexpected word", got.value, 64'd0);
                end else begin
                    want = expected_words.pop_front();
                    if (got.value !== want.value)
                        report_mismatch("value", got.value, want.value);
                    if (got.status !== want.status)
                        report_mismatch("status", 64'(got.status), 64'(want.status));
                    if (got.bit_position !== want.bit_position)
                        report_mismatch("bit_position", 64'(got.bit_position),
                                        64'(want.bit_position));
                end
                rsp_cnt <= rsp_cnt + 1;
            end
            if (i_s_tvalid && o_s_tready) begin
                rq = i_s_tdata[$bits(t_req)-1:0];
                predict_bitreader(check_state, rq, want);
                expected_words.push_back(want);
                op_seen[rq.op]++;
                status_seen[want.status]++;
            end
        end
    end

    // Watchdog: ends the run when no word moves for too long
    always @(posedge i_clk) begin
        if (!i_rst_n || (i_s_tvalid && o_s_tready) || (o_m_tvalid && i_m_tready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= STALL_LIMIT) begin
            $display("stalled for %0d cycles with %0d words still expected",
                     idle_cycles, expected_words.size());
            $display("simulation failed");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    initial begin : stimulus
        int   i;
        int   k;
        int   pick;
        int   avail;
        int   lim;
        int   nb;
        logic [2:0] rd_op;
        for (i = 0; i < 8; i++)
            op_seen[i] = 0;
        for (i = 0; i < 4; i++)
            status_seen[i] = 0;

        // directed: failures on an empty window
        add_request(OP_READ, 8'h00, 7'd64);
        add_request(OP_BYTE, 8'hFF, 7'd0);
        add_request(OP_READ, 8'h00, 7'd0);
        add_request(OP_PEEK, 8'h00, 7'd127);
        add_request(OP_SKIP, 8'h00, 7'd65);
        add_request(OP_UNDEF_TOP, 8'hFF, 7'd127);
        // fill the window, then one push too many
        for (i = 0; i < WIN_BYTES; i++)
            add_request(OP_PUSH, FILL_PATTERN[WIN_W-1-8*i -: 8], 7'd0);
        add_request(OP_PUSH, 8'hEE, 7'd127);
        // widest peek, unaligned read, misaligned byte, realign, byte read
        add_request(OP_PEEK, 8'h00, 7'd64);
        add_request(OP_READ, 8'h00, 7'd3);
        add_request(OP_BYTE, 8'h00, 7'd0);
        add_request(OP_SKIP, 8'h00, 7'd61);
        add_request(OP_BYTE, 8'h00, 7'd0);

        // random: mostly legal pushes and reads, some noise
        for (i = 0; i < RAND_ITEMS; i++) begin
            pick  = $urandom_range(99);
            avail = int'(gen_state.nbuf) * 8 - int'(gen_state.bidx);
            if (pick < 12) begin
                add_request(3'($urandom_range(7)), 8'($urandom), 7'($urandom_range(127)));
            end else if ((gen_state.nbuf < 10 && pick < 65) ||
                         (gen_state.nbuf < WIN_BYTES && pick < 35) || pick < 16) begin
                add_request(OP_PUSH, 8'($urandom), 7'($urandom_range(127)));
            end else begin
                k = $urandom_range(3);
                if (k == 3) begin
                    // aligned byte read, or sometimes a skip that realigns instead
                    if (gen_state.bidx != 0 && $urandom_range(1) == 1)
                        add_request(OP_SKIP, 8'($urandom), 7'(8 - int'(gen_state.bidx)));
                    else
                        add_request(OP_BYTE, 8'($urandom), 7'($urandom_range(127)));
                end else begin
                    lim = (avail > MAX_BITS) ? MAX_BITS : avail;
                    if (lim == 0 || $urandom_range(9) == 0)
                        nb = $urandom_range(MAX_BITS, 1);
                    else if ($urandom_range(1) == 1)
                        nb = $urandom_range((lim < 8) ? lim : 8, 1);
                    else
                        nb = $urandom_range(lim, 1);
                    rd_op = (k == 0) ? OP_READ : (k == 1) ? OP_PEEK : OP_SKIP;
                    add_request(rd_op, 8'($urandom), 7'(nb));
                end
            end
        end

        // reset, released at a falling edge
        repeat (4) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // wait for all requests to go in, all replies to come out, then drain
        @(posedge i_clk);
        while (request_words.size() != 0 || i_s_tvalid)
            @(posedge i_clk);
        while (expected_words.size() != 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("requests %0d: push %0d, read %0d, peek %0d, skip %0d, byte %0d, unknown %0d",
                 sent_cnt, op_seen[OP_PUSH], op_seen[OP_READ], op_seen[OP_PEEK],
                 op_seen[OP_SKIP], op_seen[OP_BYTE], op_seen[5] + op_seen[6] + op_seen[7]);
        $display("replies %0d: ok %0d, short %0d, full %0d, bad %0d; final position %0d",
                 rsp_cnt, status_seen[ST_OK], status_seen[ST_SHORT], status_seen[ST_FULL],
                 status_seen[ST_BAD], check_state.pos);
        if (err_cnt == 0 && expected_words.size() == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule
